FILE: hw/rtl/tspf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tspf_pkg
// Shared types, codes and constants of the transport stream packet filter.
// ----------------------------------------------------------------------------
package tspf_pkg;

   // packet format
   localparam logic [7:0] SYNC_BYTE        = 8'h47;
   localparam logic [7:0] PRIVATE_STREAM_1 = 8'hbd;
   localparam int         PID_W            = 13;
   localparam int         CC_W             = 4;

   // payload assembly limits
   localparam int PES_BUFFER_BYTES = 4096;
   localparam int UNIT_BYTES       = 184;
   // units appended while units * 184 < buffer - 184
   localparam int MAX_UNITS  = (PES_BUFFER_BYTES - UNIT_BYTES + UNIT_BYTES - 1) / UNIT_BYTES;
   localparam int UNITS_W    = $clog2(MAX_UNITS + 1);
   localparam int FUNITS_W   = 5;

   // pcr base / 90 == (base >> 1) / 45, split into 16-bit halves
   localparam int PCR_MS_W       = 27;
   localparam int HALF_TICKS     = 45;
   localparam int HI_MUL         = 65536 / HALF_TICKS;
   localparam int HI_REM         = 65536 % HALF_TICKS;
   localparam int LO_SUM_W       = 21;
   localparam int RECIP_SHIFT    = 27;
   localparam int RECIP          = (2 ** RECIP_SHIFT + HALF_TICKS - 1) / HALF_TICKS;
   localparam int RECIP_W        = 22;
   localparam int LO_PROD_W      = LO_SUM_W + RECIP_W;
   localparam int LO_QUOT_W      = 15;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_PID_SELECT = '0;

   typedef enum logic [2:0] {
      ST_APPENDED    = 3'd0,
      ST_BAD_SYNC    = 3'd1,
      ST_NO_PAYLOAD  = 3'd2,
      ST_OTHER_PID   = 3'd3,
      ST_TRANSPORT   = 3'd4,
      ST_AWAIT_LOCK  = 3'd5,
      ST_AWAIT_START = 3'd6,
      ST_BUFFER_FULL = 3'd7
   } status_type;

   typedef struct packed {
      logic [31:0] header_word;
      logic [63:0] extension_word;
   } req_payload_type;

   typedef struct packed {
      status_type            status;
      logic                  continuity_error;
      logic                  flush_previous;
      logic [FUNITS_W-1:0]   flushed_units;
      logic [PID_W-1:0]      active_pid;
      logic [PCR_MS_W-1:0]   pcr_ms;
   } rsp_payload_type;

   // register write toward the filter
   typedef struct packed {
      logic             we;
      logic [PID_W-1:0] pid;
   } pid_write_type;

   // filter verdict for one item
   typedef struct packed {
      status_type          status;
      logic                continuity_error;
      logic                flush_previous;
      logic [FUNITS_W-1:0] flushed_units;
      logic [PID_W-1:0]    active_pid;
      logic                pcr_update;
   } decision_type;

endpackage
`default_nettype wire

FILE: hw/rtl/tspf_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tspf_csr
// Register port holding pid_select; a write also reloads the locked PID.
// ----------------------------------------------------------------------------
module tspf_csr (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire [tspf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [tspf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tspf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output tspf_pkg::pid_write_type          pid_write
);

   logic [tspf_pkg::PID_W-1:0] pid_select_ff;
   logic [tspf_pkg::PID_W-1:0] pid_select_in;
   logic                       hit;
   logic                       wr;

   // address decode on the word index
   assign hit        = (csr_paddr[tspf_pkg::CSR_ADDR_W-1:2] == tspf_pkg::REG_PID_SELECT);
   assign wr         = csr_psel & csr_penable & csr_pwrite & hit;
   assign csr_pready = 1'b1;

   assign pid_select_in = wr ? csr_pwdata[tspf_pkg::PID_W-1:0] : pid_select_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pid_select_ff <= '0;
      end else begin
         pid_select_ff <= pid_select_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      if (hit) begin
         csr_prdata = tspf_pkg::CSR_DATA_W'(pid_select_ff);
      end
   end

   assign pid_write.we  = wr;
   assign pid_write.pid = csr_pwdata[tspf_pkg::PID_W-1:0];

endmodule
`default_nettype wire

FILE: hw/rtl/tspf_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tspf_filter
// Per-packet verdict and stream state: PID lock, continuity, unit assembly.
// ----------------------------------------------------------------------------
module tspf_filter (
   input  wire                              clock,
   input  wire                              reset,
   input  tspf_pkg::pid_write_type          pid_write,
   input  tspf_pkg::req_payload_type        item,
   input  wire                              commit,
   output tspf_pkg::decision_type           decision
);

   logic [tspf_pkg::PID_W-1:0]   locked_pid_ff,   locked_pid_in;
   logic [tspf_pkg::CC_W-1:0]    expected_ff,     expected_in;
   logic                         known_ff,        known_in;
   logic [tspf_pkg::UNITS_W-1:0] units_ff,        units_in;

   logic [31:0]                  hdr;
   logic [63:0]                  ext;
   logic                         sync_ok;
   logic                         terr;
   logic                         pusi;
   logic [tspf_pkg::PID_W-1:0]   pid;
   logic                         af;
   logic                         has_payload;
   logic [tspf_pkg::CC_W-1:0]    cc;
   logic [7:0]                   b4, b5, b6, b7;
   logic                         disc;
   logic                         lock_start;

   logic [tspf_pkg::PID_W-1:0]   nx_locked;
   logic [tspf_pkg::CC_W-1:0]    nx_expected;
   logic                         nx_known;
   logic [tspf_pkg::UNITS_W-1:0] nx_units;
   logic [tspf_pkg::CC_W-1:0]    cc_next;
   logic [tspf_pkg::UNITS_W-1:0] units_work;

   // header fields
   assign hdr         = item.header_word;
   assign ext         = item.extension_word;
   assign sync_ok     = (hdr[31:24] == tspf_pkg::SYNC_BYTE);
   assign terr        = hdr[23];
   assign pusi        = hdr[22];
   assign pid         = hdr[20:8];
   assign af          = hdr[5];
   assign has_payload = hdr[4];
   assign cc          = hdr[3:0];
   assign b4          = ext[63:56];
   assign b5          = ext[55:48];
   assign b6          = ext[47:40];
   assign b7          = ext[39:32];
   assign disc        = af & b5[7];
   assign lock_start  = pusi & (b4 == 8'h00) & (b5 == 8'h00) & (b6 == 8'h01)
                        & (b7 == tspf_pkg::PRIVATE_STREAM_1);
   assign cc_next     = expected_ff + tspf_pkg::CC_W'(1);

   // verdict and next state
   always_comb begin
      nx_locked                 = locked_pid_ff;
      nx_expected               = expected_ff;
      nx_known                  = known_ff;
      nx_units                  = units_ff;
      units_work                = units_ff;
      decision.status           = tspf_pkg::ST_APPENDED;
      decision.continuity_error = 1'b0;
      decision.flush_previous   = 1'b0;
      decision.flushed_units    = '0;
      decision.pcr_update       = sync_ok & af & b5[4];

      priority if (!sync_ok) begin
         decision.status = tspf_pkg::ST_BAD_SYNC;
      end else if (!has_payload) begin
         decision.status = tspf_pkg::ST_NO_PAYLOAD;
      end else if ((locked_pid_ff != '0) && (locked_pid_ff != pid)) begin
         decision.status = tspf_pkg::ST_OTHER_PID;
      end else if (terr) begin
         decision.status = tspf_pkg::ST_TRANSPORT;
      end else if ((locked_pid_ff == '0) && !lock_start) begin
         decision.status = tspf_pkg::ST_AWAIT_LOCK;
      end else begin
         if (locked_pid_ff == '0) begin
            nx_locked = pid;
         end
         // continuity check, discontinuity flag keeps the expectation
         if (!known_ff) begin
            nx_expected = cc;
            nx_known    = 1'b1;
         end else if (!disc) begin
            nx_expected = cc_next;
            if (cc != cc_next) begin
               units_work                = '0;
               nx_known                  = 1'b0;
               decision.continuity_error = 1'b1;
            end
         end
         // unit assembly
         if (!pusi && (units_work == '0)) begin
            decision.status = tspf_pkg::ST_AWAIT_START;
            nx_units        = units_work;
         end else begin
            if (pusi) begin
               decision.flush_previous = (units_work != '0);
               decision.flushed_units  = tspf_pkg::FUNITS_W'(units_work);
               units_work              = '0;
            end
            if (units_work < tspf_pkg::UNITS_W'(tspf_pkg::MAX_UNITS)) begin
               nx_units        = units_work + tspf_pkg::UNITS_W'(1);
               decision.status = tspf_pkg::ST_APPENDED;
            end else begin
               nx_units        = units_work;
               decision.status = tspf_pkg::ST_BUFFER_FULL;
            end
         end
      end
      decision.active_pid = nx_locked;
   end

   // state update when the item leaves the filter stage
   always_comb begin
      locked_pid_in = locked_pid_ff;
      expected_in   = expected_ff;
      known_in      = known_ff;
      units_in      = units_ff;
      if (pid_write.we) begin
         locked_pid_in = pid_write.pid;
      end else if (commit) begin
         locked_pid_in = nx_locked;
         expected_in   = nx_expected;
         known_in      = nx_known;
         units_in      = nx_units;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_pid_ff <= '0;
         expected_ff   <= '0;
         known_ff      <= 1'b0;
         units_ff      <= '0;
      end else begin
         locked_pid_ff <= locked_pid_in;
         expected_ff   <= expected_in;
         known_ff      <= known_in;
         units_ff      <= units_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/tspf_pcr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tspf_pcr_div
// Two-stage divide of the 33-bit PCR base by 90, giving milliseconds.
// ----------------------------------------------------------------------------
module tspf_pcr_div (
   input  wire                                clock,
   input  wire [31:0]                         half_base,
   input  wire                                load_a,
   input  wire                                load_b,
   output logic [tspf_pkg::PCR_MS_W-1:0]      quotient
);

   logic [15:0]                          x_hi;
   logic [15:0]                          x_lo;
   logic [tspf_pkg::LO_SUM_W-1:0]        lo_sum_ff,  lo_sum_in;
   logic [tspf_pkg::PCR_MS_W-1:0]        hi_quot_ff, hi_quot_in;
   logic [tspf_pkg::PCR_MS_W-1:0]        hi_quot2_ff;
   logic [tspf_pkg::LO_PROD_W-1:0]       lo_prod;
   logic [tspf_pkg::LO_QUOT_W-1:0]       lo_quot_ff, lo_quot_in;

   // x = hi * 65536 + lo = 45 * (hi * 1456) + (hi * 16 + lo)
   assign x_hi       = half_base[31:16];
   assign x_lo       = half_base[15:0];
   assign hi_quot_in = tspf_pkg::PCR_MS_W'(x_hi * tspf_pkg::PCR_MS_W'(tspf_pkg::HI_MUL));
   assign lo_sum_in  = tspf_pkg::LO_SUM_W'(x_hi) * tspf_pkg::LO_SUM_W'(tspf_pkg::HI_REM)
                       + tspf_pkg::LO_SUM_W'(x_lo);

   // remainder part divided by 45 through a reciprocal multiply
   assign lo_prod    = tspf_pkg::LO_PROD_W'(lo_sum_ff)
                       * tspf_pkg::LO_PROD_W'(tspf_pkg::RECIP);
   assign lo_quot_in = lo_prod[tspf_pkg::RECIP_SHIFT +: tspf_pkg::LO_QUOT_W];

   always_ff @(posedge clock) begin
      if (load_a) begin
         lo_sum_ff  <= lo_sum_in;
         hi_quot_ff <= hi_quot_in;
      end
      if (load_b) begin
         lo_quot_ff  <= lo_quot_in;
         hi_quot2_ff <= hi_quot_ff;
      end
   end

   assign quotient = hi_quot2_ff + tspf_pkg::PCR_MS_W'(lo_quot_ff);

endmodule
`default_nettype wire

FILE: hw/rtl/ts_packet_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ts_packet_filter_top
// Transport stream packet filter: header checks, PID lock, continuity and
// PES unit assembly, with the PCR kept in milliseconds.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | content
//  req_     | in        | req_valid / req_stall  | packet bytes 0 to 11
//  rsp_     | out       | rsp_valid / rsp_stall  | verdict, flush, PID, pcr_ms
//  csr_     | in / out  | psel, penable, pready  | pid_select at byte address 0
//
// One item per cycle while rsp_stall is low; an item passes the input
// register, the two PCR divide stages behind the filter stage and the result register.
// Synchronous active-high reset clears pipeline valids and stream state.
// A stalled result holds while the stages behind it keep filling; empty
// stages close up, and req_stall rises only when every stage is full.
// ----------------------------------------------------------------------------
module ts_packet_filter_top (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  tspf_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output tspf_pkg::rsp_payload_type        rsp_payload,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire [tspf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [tspf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tspf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   tspf_pkg::pid_write_type         pid_write;
   tspf_pkg::req_payload_type       s1_item_ff;
   tspf_pkg::decision_type          decision;
   tspf_pkg::decision_type          s2_dec_ff;
   tspf_pkg::decision_type          s3_dec_ff;
   tspf_pkg::rsp_payload_type       rsp_ff;
   logic [tspf_pkg::PCR_MS_W-1:0]   clock_ms_ff, clock_ms_in;
   logic [tspf_pkg::PCR_MS_W-1:0]   quotient;

   logic s1_valid_ff,  s1_valid_in;
   logic s2_valid_ff,  s2_valid_in;
   logic s3_valid_ff,  s3_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ready, s3_ready, s2_ready, s1_ready;
   logic s1_move, s3_move;

   // register port
   tspf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pid_write   (pid_write)
   );

   // pipeline flow: a stage takes new data when empty or moving on
   assign rsp_ready = !rsp_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign s1_move   = s1_valid_ff && s2_ready;
   assign s3_move   = s3_valid_ff && rsp_ready;

   assign s1_valid_in  = s1_ready  ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = s2_ready  ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = s3_ready  ? s2_valid_ff : s3_valid_ff;
   assign rsp_valid_in = rsp_ready ? s3_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clock_ms_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         clock_ms_ff  <= clock_ms_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_item_ff <= req_payload;
      end
   end

   // filter stage with stream state
   tspf_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .pid_write (pid_write),
      .item      (s1_item_ff),
      .commit    (s1_move),
      .decision  (decision)
   );

   // pcr divide runs beside the verdict
   tspf_pcr_div u_pcr_div (
      .clock     (clock),
      .half_base (s1_item_ff.extension_word[47:16]),
      .load_a    (s2_ready),
      .load_b    (s3_ready),
      .quotient  (quotient)
   );

   // verdict follows the divide stages
   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_dec_ff <= decision;
      end
      if (s3_ready) begin
         s3_dec_ff <= s2_dec_ff;
      end
   end

   // millisecond clock, updated in item order
   always_comb begin
      clock_ms_in = clock_ms_ff;
      if (s3_move && s3_dec_ff.pcr_update) begin
         clock_ms_in = quotient;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s3_move) begin
         rsp_ff.status           <= s3_dec_ff.status;
         rsp_ff.continuity_error <= s3_dec_ff.continuity_error;
         rsp_ff.flush_previous   <= s3_dec_ff.flush_previous;
         rsp_ff.flushed_units    <= s3_dec_ff.flushed_units;
         rsp_ff.active_pid       <= s3_dec_ff.active_pid;
         rsp_ff.pcr_ms           <= clock_ms_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
